// ----- sv/ged_pkg.sv -----
// ----------------------------------------------------------------------------
// ged_pkg
// Shared types and constants of the gradient edge detector: frame limits,
// operator codes, register indexes and the transaction payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ged_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int POS_W = 11;
  localparam int DIM_W = 12;
  localparam int PIX_W = 8;
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
  localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  localparam logic [7:0] MAG_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_SOBEL   = 2'd0,
    OP_PREWITT = 2'd1,
    OP_ROBERTS = 2'd2,
    OP_ROB_ALT = 2'd3
  } edge_op_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_EDGE_OPERATOR = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0]       magnitude;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             last_of_frame;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/ged_ram.sv -----
// ----------------------------------------------------------------------------
// ged_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
`default_nettype none

module ged_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/gradient_edge_detector_top.sv -----
// ----------------------------------------------------------------------------
// gradient_edge_detector_top
// Sobel, Prewitt or Roberts cross edge magnitude over a raster stream of grey
// pixels, with both previous rows held in one line memory.
//
//   Channel  Direction  Payload                                   Handshake
//   in_      input      pixel, frame_start                        valid/ready
//   out_     output     magnitude, center_row, center_col, last   valid/ready
//   cfg_     input      register index, write data                valid/ready
//
// One pixel is accepted per clock while in_ready is high. A pixel whose row
// and column are both two or more yields a result, which passes through the
// stage 1 and stage 2 registers into the result buffer. The line memory is
// read when a pixel is accepted and written in the cycle after, with forwarding
// when the same column is touched back to back. Reset clears counters, window
// and control state; the line memory is not cleared. Results queue in a four
// entry buffer, and the input stalls only when that buffer could overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_edge_detector_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ged_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ged_pkg::out_t        out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [11:0]     cfg_data
);

  localparam int POS_W  = ged_pkg::POS_W;
  localparam int DIM_W  = ged_pkg::DIM_W;
  localparam int PIX_W  = ged_pkg::PIX_W;
  localparam int ADDR_W = ged_pkg::ADDR_W;

  // Configuration registers.
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  ged_pkg::edge_op_t  op_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ged_pkg::RESET_WIDTH;
      height_r <= ged_pkg::RESET_HEIGHT;
      op_r     <= ged_pkg::OP_SOBEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ged_pkg::cfg_index_t'(cfg_index))
        ged_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_data;
        ged_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_data;
        ged_pkg::CFG_EDGE_OPERATOR: op_r     <= ged_pkg::edge_op_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Effective frame size.
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    if (width_r < ged_pkg::MIN_DIM) begin
      w_eff = ged_pkg::MIN_DIM;
    end else if (width_r > ged_pkg::MAX_W_DIM) begin
      w_eff = ged_pkg::MAX_W_DIM;
    end else begin
      w_eff = width_r;
    end
    if (height_r < ged_pkg::MIN_DIM) begin
      h_eff = ged_pkg::MIN_DIM;
    end else if (height_r > ged_pkg::MAX_H_DIM) begin
      h_eff = ged_pkg::MAX_H_DIM;
    end else begin
      h_eff = height_r;
    end
  end

  // Stage 0: position of the accepted pixel and line memory read.
  logic [POS_W-1:0] row_cnt_r;
  logic [POS_W-1:0] col_cnt_r;
  logic [POS_W-1:0] row_cur;
  logic [POS_W-1:0] col_cur;
  logic [DIM_W-1:0] row_p1;
  logic [DIM_W-1:0] col_p1;
  logic [POS_W-1:0] row_cnt_nxt;
  logic [POS_W-1:0] col_cnt_nxt;
  logic             accept;
  logic             emit_cur;
  logic             last_cur;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (in_data.frame_start || ({1'b0, col_cnt_r} >= w_eff)) begin
      col_cur = '0;
    end else begin
      col_cur = col_cnt_r;
    end
    if (in_data.frame_start || ({1'b0, row_cnt_r} >= h_eff)) begin
      row_cur = '0;
    end else begin
      row_cur = row_cnt_r;
    end
    row_p1 = {1'b0, row_cur} + DIM_W'(1);
    col_p1 = {1'b0, col_cur} + DIM_W'(1);
    if (col_p1 >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_p1 >= h_eff) ? '0 : row_p1[POS_W-1:0];
    end else begin
      col_cnt_nxt = col_p1[POS_W-1:0];
      row_cnt_nxt = row_cur;
    end
    emit_cur = (row_cur >= POS_W'(2)) && (col_cur >= POS_W'(2));
    last_cur = (row_p1 == h_eff) && (col_p1 == w_eff);
  end

  // Stage 1: line memory read-modify-write and window shift.
  logic                   s1_v_r;
  logic [PIX_W-1:0]       s1_px_r;
  logic [POS_W-1:0]       s1_row_r;
  logic [POS_W-1:0]       s1_col_r;
  logic                   s1_emit_r;
  logic                   s1_last_r;
  logic                   s1_fwd_r;
  logic [2*PIX_W-1:0]     s1_fwd_data_r;
  logic [2*PIX_W-1:0]     ram_rdata;
  logic [2*PIX_W-1:0]     line_rd;
  logic [2*PIX_W-1:0]     line_wr;
  logic                   fwd_hit;

  assign line_rd = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign line_wr = {line_rd[PIX_W-1:0], s1_px_r};
  assign fwd_hit = s1_v_r && (s1_col_r == col_cur);

  ged_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (ged_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r[ADDR_W-1:0]),
    .wdata (line_wr),
    .re    (accept),
    .raddr (col_cur[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Stage 2: magnitude from the window.
  logic [PIX_W-1:0] win_r [9];
  logic             s2_v_r;
  logic [POS_W-1:0] s2_row_r;
  logic [POS_W-1:0] s2_col_r;
  logic             s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r && s1_emit_r;
      if (accept) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end
      if (s1_v_r) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3+0] <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= line_rd[2*PIX_W-1:PIX_W];
        win_r[5] <= line_rd[PIX_W-1:0];
        win_r[8] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= in_data.pixel;
      s1_row_r      <= row_cur;
      s1_col_r      <= col_cur;
      s1_emit_r     <= emit_cur;
      s1_last_r     <= last_cur;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= line_wr;
    end
    if (s1_v_r) begin
      s2_row_r  <= s1_row_r - POS_W'(1);
      s2_col_r  <= s1_col_r - POS_W'(1);
      s2_last_r <= s1_last_r;
    end
  end

  logic [9:0]  sum_a;
  logic [9:0]  sum_b;
  logic [9:0]  sum_c;
  logic [9:0]  sum_d;
  logic [9:0]  gx;
  logic [9:0]  gy;
  logic [10:0] gsum;
  logic [7:0]  mag;

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    sum_c = '0;
    sum_d = '0;
    unique case (op_r)
      ged_pkg::OP_SOBEL: begin
        sum_a = 10'(win_r[6]) + {1'b0, win_r[7], 1'b0} + 10'(win_r[8]);
        sum_b = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
        sum_c = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(win_r[6]);
        sum_d = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(win_r[8]);
      end
      ged_pkg::OP_PREWITT: begin
        sum_a = 10'(win_r[6]) + 10'(win_r[7]) + 10'(win_r[8]);
        sum_b = 10'(win_r[0]) + 10'(win_r[1]) + 10'(win_r[2]);
        sum_c = 10'(win_r[0]) + 10'(win_r[3]) + 10'(win_r[6]);
        sum_d = 10'(win_r[2]) + 10'(win_r[5]) + 10'(win_r[8]);
      end
      ged_pkg::OP_ROBERTS, ged_pkg::OP_ROB_ALT: begin
        sum_a = 10'(win_r[4]);
        sum_b = 10'(win_r[8]);
        sum_c = 10'(win_r[7]);
        sum_d = 10'(win_r[5]);
      end
      default: ;
    endcase
    gx   = (sum_a >= sum_b) ? (sum_a - sum_b) : (sum_b - sum_a);
    gy   = (sum_c >= sum_d) ? (sum_c - sum_d) : (sum_d - sum_c);
    gsum = 11'(gx) + 11'(gy);
    mag  = (gsum > 11'(ged_pkg::MAG_MAX)) ? ged_pkg::MAG_MAX : gsum[7:0];
  end

  // Result buffer.
  ged_pkg::out_t fifo_r [4];
  logic [1:0]    wr_ptr_r;
  logic [1:0]    rd_ptr_r;
  logic [2:0]    cnt_r;
  logic [2:0]    occupancy;
  logic          push;
  logic          pop;

  assign push      = s2_v_r;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign occupancy = cnt_r + {2'b00, s1_v_r} + {2'b00, s2_v_r};
  assign in_ready  = (occupancy < 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r].magnitude     <= mag;
      fifo_r[wr_ptr_r].center_row    <= s2_row_r;
      fifo_r[wr_ptr_r].center_col    <= s2_col_r;
      fifo_r[wr_ptr_r].last_of_frame <= s2_last_r;
    end
  end

endmodule

`default_nettype wire
